// ----- hw/rtl/coalescing_refresh_tracker_top_macros.svh -----
// Assertion macros used by the refresh tracker top level.
`ifndef COALESCING_REFRESH_TRACKER_TOP_MACROS_SVH
`define COALESCING_REFRESH_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
// Check that a condition holds in the same cycle as its trigger.
`define CRT_ASSERT_NOW(lbl, clk_s, rst_n_s, trig, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (trig) |-> (cond)) \
		else $error("assertion failed");
// Check that a condition holds in the cycle after its trigger.
`define CRT_ASSERT_NEXT(lbl, clk_s, rst_n_s, trig, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (trig) |=> (cond)) \
		else $error("assertion failed");
`else
`define CRT_ASSERT_NOW(lbl, clk_s, rst_n_s, trig, cond)
`define CRT_ASSERT_NEXT(lbl, clk_s, rst_n_s, trig, cond)
`endif
`endif

// ----- hw/rtl/crt_pkg.sv -----
// Package with the types, codes and constants of the refresh tracker.
package crt_pkg;

	// Number of slots by default.
	localparam int CRT_NUM_KINDS = 8;
	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	localparam int KIND_W = 4;
	localparam int OP_W   = 3;
	localparam int WORD_W = 64;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

	// Operation codes on the input channel.
	localparam logic [OP_W-1:0] OP_REQUEST    = 3'd0;
	localparam logic [OP_W-1:0] OP_COMPLETE   = 3'd1;
	localparam logic [OP_W-1:0] OP_EXPIRE     = 3'd2;
	localparam logic [OP_W-1:0] OP_ABORT      = 3'd3;
	localparam logic [OP_W-1:0] OP_IS_CURRENT = 3'd4;
	localparam logic [OP_W-1:0] OP_IS_BUSY    = 3'd5;

	// Input item.
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] generation_tag;
		logic [WORD_W-1:0] now_ms;
		logic [WORD_W-1:0] timeout_ms;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic              dispatch;
		logic              coalesced;
		logic              accepted;
		logic              dispatch_next;
		logic              expired;
		logic              had_pending;
		logic              answer;
		logic [WORD_W-1:0] generation_out;
		logic [WORD_W-1:0] next_generation;
	} rsp_item_t;

	// Classified command; everything that can only give an all-zero result is CMD_NONE.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_REQUEST,
		CMD_COMPLETE,
		CMD_EXPIRE,
		CMD_ABORT,
		CMD_IS_CURRENT,
		CMD_IS_BUSY
	} cmd_t;

	// Queue entry handed from the front to the back.
	typedef struct packed {
		cmd_t              cmd;
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] now;
		logic [WORD_W-1:0] tmo;
	} q_entry_t;

	// Head of the queue as seen by the back.
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

// ----- hw/rtl/crt_front.sv -----
// Front of the refresh tracker: classifies input items and queues them.
module crt_front import crt_pkg::*; #(
	parameter int NUM_KINDS = CRT_NUM_KINDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	input  logic      pop,
	output q_head_t   head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [KIND_W:0]  KIND_LIMIT = (KIND_W + 1)'(NUM_KINDS);
	localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);

	q_entry_t         cls;
	logic             kind_ok;
	logic             tag_ok;
	logic             push;
	q_entry_t         entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Classify the item: a bad kind, a zero tag on complete, abort or is_current,
	// an unknown time on expire or an unused code all fold into the no-op command.
	always_comb begin
		kind_ok = {1'b0, req.kind} < KIND_LIMIT;
		tag_ok  = req.generation_tag != '0;
		cls.cmd  = CMD_NONE;
		cls.kind = req.kind;
		cls.tag  = req.generation_tag;
		cls.now  = req.now_ms;
		cls.tmo  = req.timeout_ms;
		if (kind_ok) begin
			unique case (req.operation)
				OP_REQUEST:    cls.cmd = CMD_REQUEST;
				OP_COMPLETE:   cls.cmd = tag_ok ? CMD_COMPLETE : CMD_NONE;
				OP_EXPIRE:     cls.cmd = (req.now_ms != '0) ? CMD_EXPIRE : CMD_NONE;
				OP_ABORT:      cls.cmd = tag_ok ? CMD_ABORT : CMD_NONE;
				OP_IS_CURRENT: cls.cmd = tag_ok ? CMD_IS_CURRENT : CMD_NONE;
				OP_IS_BUSY:    cls.cmd = CMD_IS_BUSY;
				default:       cls.cmd = CMD_NONE;
			endcase
		end
	end

	// Queue handshake.
	assign req_stall  = count_q == CNT_FULL;
	assign push       = req_valid && !req_stall;
	assign head.valid = count_q != '0;
	assign head.entry = entries_q[rd_ptr_q];

	// Queue storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/crt_back.sv -----
// Back of the refresh tracker: slot state update and result register.
module crt_back import crt_pkg::*; #(
	parameter int NUM_KINDS = CRT_NUM_KINDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_head_t   head,
	output logic      pop,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int KIDX_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

	logic              busy_q    [NUM_KINDS];
	logic              again_q   [NUM_KINDS];
	logic [WORD_W-1:0] gen_q     [NUM_KINDS];
	logic [WORD_W-1:0] saved_q   [NUM_KINDS];
	logic [WORD_W-1:0] due_q     [NUM_KINDS];

	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic [KIDX_W-1:0] k;
	logic              busy;
	logic              again;
	logic [WORD_W-1:0] gen;
	logic [WORD_W-1:0] gen_inc;
	logic              gen_max;
	logic              match;
	logic [WORD_W-1:0] tmo_sel;
	logic [WORD_W:0]   due_sum;
	logic [WORD_W-1:0] due_new;

	logic              busy_n;
	logic              again_n;
	logic [WORD_W-1:0] gen_n;
	logic [WORD_W-1:0] saved_n;
	logic [WORD_W-1:0] due_n;
	rsp_item_t         res;

	// Take the head of the queue when the result register is free or draining.
	assign pop       = head.valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read the addressed slot.
	assign k       = head.entry.kind[KIDX_W-1:0];
	assign busy    = busy_q[k];
	assign again   = again_q[k];
	assign gen     = gen_q[k];
	assign gen_inc = gen + 1'b1;
	assign gen_max = gen == ALL_ONES;
	assign match   = busy && (gen == head.entry.tag);

	// Due time: zero when time or timeout is unknown, else a saturating sum.
	always_comb begin
		tmo_sel = (head.entry.cmd == CMD_REQUEST) ? head.entry.tmo : saved_q[k];
		due_sum = {1'b0, head.entry.now} + {1'b0, tmo_sel};
		if (head.entry.now == '0 || tmo_sel == '0) begin
			due_new = '0;
		end else if (due_sum[WORD_W]) begin
			due_new = ALL_ONES;
		end else begin
			due_new = due_sum[WORD_W-1:0];
		end
	end

	// Next slot state and result for the head item.
	always_comb begin
		busy_n  = busy;
		again_n = again;
		gen_n   = gen;
		saved_n = saved_q[k];
		due_n   = due_q[k];
		res     = '0;
		unique case (head.entry.cmd)
			CMD_REQUEST: begin
				if (busy) begin
					again_n            = 1'b1;
					res.coalesced      = 1'b1;
					res.generation_out = gen;
				end else if (gen_max) begin
					again_n = 1'b0;
				end else begin
					gen_n              = gen_inc;
					busy_n             = 1'b1;
					again_n            = 1'b0;
					saved_n            = head.entry.tmo;
					due_n              = due_new;
					res.dispatch       = 1'b1;
					res.generation_out = gen_inc;
				end
			end
			CMD_COMPLETE: begin
				if (match) begin
					res.accepted       = 1'b1;
					res.generation_out = head.entry.tag;
					if (!again) begin
						busy_n = 1'b0;
						due_n  = '0;
					end else if (gen_max) begin
						busy_n  = 1'b0;
						again_n = 1'b0;
					end else begin
						again_n             = 1'b0;
						gen_n               = gen_inc;
						due_n               = due_new;
						res.dispatch_next   = 1'b1;
						res.next_generation = gen_inc;
					end
				end
			end
			CMD_EXPIRE: begin
				if (busy && due_q[k] != '0 && head.entry.now >= due_q[k]) begin
					res.expired        = 1'b1;
					res.had_pending    = again;
					res.generation_out = gen;
					busy_n             = 1'b0;
					again_n            = 1'b0;
					due_n              = '0;
				end
			end
			CMD_ABORT: begin
				if (match) begin
					busy_n     = 1'b0;
					again_n    = 1'b0;
					due_n      = '0;
					res.answer = 1'b1;
				end
			end
			CMD_IS_CURRENT: res.answer = match;
			CMD_IS_BUSY:    res.answer = busy;
			default: begin
				res = '0;
			end
		endcase
	end

	// Slot state: written back for the item taken from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KINDS; i++) begin
				busy_q[i]  <= 1'b0;
				again_q[i] <= 1'b0;
				gen_q[i]   <= '0;
				saved_q[i] <= '0;
				due_q[i]   <= '0;
			end
		end else if (pop) begin
			busy_q[k]  <= busy_n;
			again_q[k] <= again_n;
			gen_q[k]   <= gen_n;
			saved_q[k] <= saved_n;
			due_q[k]   <= due_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= res;
		end
	end

endmodule

// ----- hw/rtl/coalescing_refresh_tracker_top.sv -----
// Top level of the coalescing refresh tracker.
//
// Input channel req/req_valid/req_stall carries one operation per item:
// request, complete, expire, abort, is_current or is_busy on one slot
// (kind). Output channel rsp/rsp_valid/rsp_stall returns exactly one
// result item per input item, in order.
// An accepted item enters a two-entry queue after classification; the
// back end takes one item per cycle from the queue while the result register
// is free or draining, reads and rewrites the addressed slot registers in
// that cycle and loads the result register.
// An item is registered in the queue, then its result in the result register.
// Throughput: one item per cycle while the output is not stalled, set by the
// read-modify-write of the slot registers in the cycle the item is taken.
// When the receiver holds rsp_stall, the result stays put, the back end
// stops, the queue fills and req_stall rises once it is full.
// Reset clears all slots (busy, pending, generation, timeout, due time),
// the queue and the result valid flag; the block is ready at once.
`include "coalescing_refresh_tracker_top_macros.svh"
module coalescing_refresh_tracker_top import crt_pkg::*; #(
	parameter int NUM_KINDS = CRT_NUM_KINDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	q_head_t head;
	logic    pop;

	// Classification and queue.
	crt_front #(
		.NUM_KINDS (NUM_KINDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.pop       (pop),
		.head      (head)
	);

	// Slot state and result register.
	crt_back #(
		.NUM_KINDS (NUM_KINDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A follow-up dispatch always rides on an accepted completion, one generation on.
	`CRT_ASSERT_NOW(a_next_gen, clk, arst_n, rsp_valid && rsp.dispatch_next, rsp.accepted && rsp.next_generation == rsp.generation_out + 1'b1)
	// A result reports at most one kind of outcome.
	`CRT_ASSERT_NOW(a_one_outcome, clk, arst_n, rsp_valid, $countones({rsp.dispatch, rsp.coalesced, rsp.accepted, rsp.expired, rsp.answer}) <= 1)
	// A fresh dispatch never names generation zero.
	`CRT_ASSERT_NOW(a_gen_nonzero, clk, arst_n, rsp_valid && rsp.dispatch, rsp.generation_out != '0)
	// A queued item is always turned into a result on the next edge when the output is free.
	`CRT_ASSERT_NEXT(a_drain, clk, arst_n, head.valid && !rsp_stall, rsp_valid)

endmodule
